FILE: design/bounded_deque_with_erase_top_assert.svh
// assertion macros for the bounded deque top level
// no dependencies; included by bounded_deque_with_erase_top
`ifndef BOUNDED_DEQUE_WITH_ERASE_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_ERASE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BDQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bdq_pkg.sv
// shared types and constants for the bounded deque
// no dependencies
package bdq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int CMD_W          = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_ERASE      = 3'd4,
        CMD_CLEAR      = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_REPORT
    } t_state;

    // what every cell does on a clock edge
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_TAKE_LEFT,
        OP_TAKE_RIGHT,
        OP_LOAD_TAIL,
        OP_COMPARE,
        OP_ERASE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     is_tail;
        logic     in_range;
    } t_cell_ctl;

endpackage

FILE: design/bdq_cell.sv
// one storage cell of the deque chain
// depends on bdq_pkg
module bdq_cell import bdq_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic                  i_found_left,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_found
);

    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic                  r_match, n_match;

    // found so far: a match here or in any cell closer to the front
    assign o_found = i_found_left | r_match;
    assign o_data  = r_data;

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        case (i_ctl.op)
            OP_TAKE_LEFT:  n_data = i_left_data;
            OP_TAKE_RIGHT: n_data = i_right_data;
            OP_LOAD_TAIL:  if (i_ctl.is_tail) n_data = i_value;
            OP_COMPARE:    n_match = i_ctl.in_range && (r_data == i_value);
            OP_ERASE:      if (o_found) n_data = i_right_data;
            default:       ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

endmodule

FILE: design/bounded_deque_with_erase_top.sv
// bounded deque with erase: an accepted command updates the cell row in the EXEC state
// (then SHIFT for erase) and its result is strobed in REPORT; busy is high in EXEC and
// SHIFT, so no new command is taken there, and the next one can be taken during REPORT
// the receiver cannot stall; o_valid marks each result for one cycle
// reset is synchronous active low: clears control state and the element count,
// cell contents are left undefined and are never read before being written
module bounded_deque_with_erase_top import bdq_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CMD_W-1:0]          i_command,
    input  logic signed [FIELD_W-1:0] i_value,
    output logic                      o_valid,
    output logic                      o_ok,
    output logic [CNT_W-1:0]          o_count,
    output logic                      o_is_empty,
    output logic signed [FIELD_W-1:0] o_front_value,
    output logic signed [FIELD_W-1:0] o_back_value
);

`include "bounded_deque_with_erase_top_assert.svh"

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // control registers
    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [DATA_WIDTH-1:0] r_val;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_ok, n_ok;

    logic     accept;
    logic     full, empty;
    t_cell_op cell_op;

    // cell chain wiring
    logic [DATA_WIDTH-1:0] w_data  [DEPTH];
    logic                  w_found [DEPTH+1];
    logic                  w_last  [DEPTH];
    logic [DATA_WIDTH-1:0] back_data;

    assign accept = start && !busy;
    assign full   = (r_count == FULL_CNT);
    assign empty  = (r_count == '0);

    // ---------------------------------------------------------------
    // state machine: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (accept) n_state = S_EXEC;
            S_EXEC:   n_state = (r_cmd == CMD_ERASE) ? S_SHIFT : S_REPORT;
            S_SHIFT:  n_state = S_REPORT;
            S_REPORT: n_state = accept ? S_EXEC : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // state machine: outputs (cell operation, handshake)
    // ---------------------------------------------------------------
    always_comb begin
        cell_op = OP_HOLD;
        busy    = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: ;
            S_EXEC: begin
                busy = 1'b1;
                case (r_cmd)
                    CMD_PUSH_FRONT: if (!full)  cell_op = OP_TAKE_LEFT;
                    CMD_PUSH_BACK:  if (!full)  cell_op = OP_LOAD_TAIL;
                    CMD_POP_FRONT:  if (!empty) cell_op = OP_TAKE_RIGHT;
                    CMD_ERASE:      cell_op = OP_COMPARE;
                    default:        ;
                endcase
            end
            S_SHIFT: begin
                busy    = 1'b1;
                cell_op = OP_ERASE;
            end
            S_REPORT: o_valid = 1'b1;
            default:  ;
        endcase
    end

    // ---------------------------------------------------------------
    // element count and success flag
    // ---------------------------------------------------------------
    always_comb begin
        n_count = r_count;
        n_ok    = r_ok;
        case (r_state)
            S_EXEC: begin
                n_ok = 1'b0;
                case (r_cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: if (!full) begin
                        n_count = r_count + 1'b1;
                        n_ok    = 1'b1;
                    end
                    CMD_POP_FRONT, CMD_POP_BACK: if (!empty) begin
                        n_count = r_count - 1'b1;
                        n_ok    = 1'b1;
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                        n_ok    = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_SHIFT: begin
                // match bits were registered in the compare cycle
                n_ok = w_found[DEPTH];
                if (w_found[DEPTH]) n_count = r_count - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ok    <= n_ok;
        end
    end

    // command beat capture; value reduced to the element width, zero extended
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= t_cmd'(i_command);
            r_val <= DATA_WIDTH'($unsigned(i_value));
        end
    end

    // ---------------------------------------------------------------
    // row of cells, front at index 0
    // ---------------------------------------------------------------
    assign w_found[0] = 1'b0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_cell_ctl             ctl;
        logic [DATA_WIDTH-1:0] left_data, right_data;

        assign ctl.op       = cell_op;
        assign ctl.is_tail  = (r_count == CNT_W'(k));
        assign ctl.in_range = (CNT_W'(k) < r_count);
        assign w_last[k]    = (r_count == CNT_W'(k + 1));

        // push front feeds the new value into the front cell
        if (k == 0) begin : g_front
            assign left_data = r_val;
        end else begin : g_mid
            assign left_data = w_data[k-1];
        end

        if (k == DEPTH - 1) begin : g_end
            assign right_data = w_data[k];
        end else begin : g_inner
            assign right_data = w_data[k+1];
        end

        bdq_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_value     (r_val),
            .i_left_data (left_data),
            .i_right_data(right_data),
            .i_found_left(w_found[k]),
            .o_data      (w_data[k]),
            .o_found     (w_found[k+1])
        );
    end

    // back element: the one cell whose position is count-1
    always_comb begin
        back_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_last[k]) back_data = back_data | w_data[k];
        end
    end

    // ---------------------------------------------------------------
    // result beat
    // ---------------------------------------------------------------
    assign o_ok          = r_ok;
    assign o_count       = r_count;
    assign o_is_empty    = empty;
    assign o_front_value = empty ? '0 : $signed(FIELD_W'(w_data[0]));
    assign o_back_value  = empty ? '0 : $signed(FIELD_W'(back_data));

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `BDQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, o_valid, o_count <= FULL_CNT, "count over depth")
    `BDQ_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, start && !busy, !o_valid && busy, "result too early")
    `BDQ_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_valid && o_is_empty, (o_front_value == '0) && (o_back_value == '0), "empty deque reports data")
    `BDQ_ASSERT_NEXT(a_shift_after_compare, i_clk, i_rst_n, (r_state == S_EXEC) && (r_cmd == CMD_ERASE), r_state == S_SHIFT, "erase skipped shift")

endmodule
